// ===== rtl/gpje_pkg.sv =====
`default_nettype none
package gpje_pkg;

    localparam int COUNT_W      = 15;
    localparam int AXIS_W       = 8;
    localparam int PORT_W       = 3;
    localparam int BTN_W        = 4;
    localparam int FRAME_W      = 24;
    localparam int DATA_W       = 8;
    localparam int CFG_IDX_W    = 1;
    localparam int NUM_AXES     = 4;

    localparam int BASE_TICKS   = 2000;
    localparam int AXIS_SHIFT   = 6;
    localparam int HALF_BIT_US  = 25;

    localparam int FRAME_STEPS  = 48;
    localparam int STEP_W       = 6;

    localparam logic [PORT_W-1:0] JOY_PORT  = 3'd1;
    localparam logic [DATA_W-1:0] UNHANDLED = 8'hFF;

    typedef enum logic [1:0] {
        OP_READ     = 2'd0,
        OP_WRITE    = 2'd1,
        OP_CNT_TICK = 2'd2,
        OP_US_TICK  = 2'd3
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SERIAL_MODE = 1'b0,
        CFG_PLAYERS     = 1'b1
    } cfg_idx_t;

    // Per-transaction control towards the timer block
    typedef struct packed {
        logic load;
        logic count_tick;
        logic us_tick;
    } timer_ctl_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              handled;
    } rsp_t;

    function automatic logic [COUNT_W-1:0] load_value(input logic [AXIS_W-1:0] axis);
        logic [COUNT_W-1:0] v;
        v = COUNT_W'(BASE_TICKS) + (COUNT_W'(axis) << AXIS_SHIFT);
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/gpje_req_if.sv =====
`default_nettype none
interface gpje_req_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     opcode;
    logic [gpje_pkg::PORT_W-1:0]    port_low;
    logic [gpje_pkg::AXIS_W-1:0]    axis_a_x;
    logic [gpje_pkg::AXIS_W-1:0]    axis_a_y;
    logic [gpje_pkg::AXIS_W-1:0]    axis_b_x;
    logic [gpje_pkg::AXIS_W-1:0]    axis_b_y;
    logic [gpje_pkg::BTN_W-1:0]     button_bits;
    logic [gpje_pkg::FRAME_W-1:0]   pad_frame;

    modport source (
        output valid, opcode, port_low, axis_a_x, axis_a_y, axis_b_x, axis_b_y,
               button_bits, pad_frame,
        input  ready
    );
    modport sink (
        input  valid, opcode, port_low, axis_a_x, axis_a_y, axis_b_x, axis_b_y,
               button_bits, pad_frame,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/gpje_rsp_if.sv =====
`default_nettype none
interface gpje_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [gpje_pkg::DATA_W-1:0]    read_data;
    logic                           handled;

    modport source (output valid, read_data, handled, input ready);
    modport sink (input valid, read_data, handled, output ready);
endinterface
`default_nettype wire

// ===== rtl/gpje_cfg_if.sv =====
`default_nettype none
interface gpje_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [gpje_pkg::CFG_IDX_W-1:0]     index;
    logic                               data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/gpje_timers.sv =====
`default_nettype none
module gpje_timers #(
    parameter int HALF_BIT_US = gpje_pkg::HALF_BIT_US
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire gpje_pkg::timer_ctl_t                ctl,
    input  wire logic [gpje_pkg::AXIS_W-1:0]         axis_a_x,
    input  wire logic [gpje_pkg::AXIS_W-1:0]         axis_a_y,
    input  wire logic [gpje_pkg::AXIS_W-1:0]         axis_b_x,
    input  wire logic [gpje_pkg::AXIS_W-1:0]         axis_b_y,
    output logic [gpje_pkg::NUM_AXES-1:0]            running,
    output logic [gpje_pkg::STEP_W-1:0]              step
);

    localparam int SUB_W = (HALF_BIT_US > 1) ? $clog2(HALF_BIT_US) : 1;

    logic [gpje_pkg::COUNT_W-1:0] cnt_reg  [gpje_pkg::NUM_AXES];
    logic [gpje_pkg::COUNT_W-1:0] cnt_next [gpje_pkg::NUM_AXES];
    logic [gpje_pkg::COUNT_W-1:0] load_val [gpje_pkg::NUM_AXES];
    logic [SUB_W-1:0]             sub_reg, sub_next;
    logic [gpje_pkg::STEP_W-1:0]  step_reg, step_next;

    assign load_val[0] = gpje_pkg::load_value(axis_a_x);
    assign load_val[1] = gpje_pkg::load_value(axis_a_y);
    assign load_val[2] = gpje_pkg::load_value(axis_b_x);
    assign load_val[3] = gpje_pkg::load_value(axis_b_y);

    always_comb
    begin
        for (int i = 0; i < gpje_pkg::NUM_AXES; i++)
        begin
            cnt_next[i] = cnt_reg[i];
            if (ctl.load)
                cnt_next[i] = load_val[i];
            else if (ctl.count_tick && (cnt_reg[i] != '0))
                cnt_next[i] = cnt_reg[i] - 1'b1;
            running[i] = (cnt_reg[i] != '0);
        end
    end

    // Phase kept as step and microsecond-within-step, so no divider is needed
    always_comb
    begin
        sub_next  = sub_reg;
        step_next = step_reg;
        if (ctl.us_tick)
        begin
            if (sub_reg == SUB_W'(HALF_BIT_US - 1))
            begin
                sub_next = '0;
                if (step_reg == gpje_pkg::STEP_W'(gpje_pkg::FRAME_STEPS - 1))
                    step_next = '0;
                else
                    step_next = step_reg + 1'b1;
            end
            else
            begin
                sub_next = sub_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < gpje_pkg::NUM_AXES; i++)
                cnt_reg[i] <= '0;
            sub_reg  <= '0;
            step_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < gpje_pkg::NUM_AXES; i++)
                cnt_reg[i] <= cnt_next[i];
            sub_reg  <= sub_next;
            step_reg <= step_next;
        end
    end

    assign step = step_reg;

endmodule
`default_nettype wire

// ===== rtl/gpje_read_mux.sv =====
`default_nettype none
module gpje_read_mux (
    input  wire logic                               serial_pad_mode,
    input  wire logic                               players_present,
    input  wire logic [gpje_pkg::PORT_W-1:0]        port_low,
    input  wire logic [gpje_pkg::BTN_W-1:0]         button_bits,
    input  wire logic [gpje_pkg::FRAME_W-1:0]       pad_frame,
    input  wire logic [gpje_pkg::NUM_AXES-1:0]      running,
    input  wire logic [gpje_pkg::STEP_W-1:0]        step,
    output gpje_pkg::rsp_t                          rsp
);

    logic [gpje_pkg::STEP_W-1:0] index;
    logic                        pad_bit;
    logic [gpje_pkg::DATA_W-1:0] serial_byte;
    logic [gpje_pkg::DATA_W-1:0] analog_byte;

    // Frame is sent from the top half-step downwards
    assign index   = gpje_pkg::STEP_W'(gpje_pkg::FRAME_STEPS - 1) - step;
    assign pad_bit = pad_frame[index[gpje_pkg::STEP_W-1:1]];

    assign serial_byte = {2'b00, pad_bit, index[0], 4'b1111};
    assign analog_byte = {button_bits, running};

    always_comb
    begin
        rsp.read_data = gpje_pkg::UNHANDLED;
        rsp.handled   = 1'b0;
        if ((port_low == gpje_pkg::JOY_PORT) && players_present)
        begin
            rsp.handled   = 1'b1;
            rsp.read_data = serial_pad_mode ? serial_byte : analog_byte;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/gpje_out_buf.sv =====
`default_nettype none
module gpje_out_buf (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire gpje_pkg::rsp_t push_data,
    output logic                space,
    gpje_rsp_if.source          rsp
);

    logic           out_valid_reg, out_valid_next;
    logic           skid_valid_reg, skid_valid_next;
    gpje_pkg::rsp_t out_reg, out_next;
    gpje_pkg::rsp_t skid_reg, skid_next;
    logic           pop;

    assign pop   = out_valid_reg && rsp.ready;
    assign space = !skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                out_next = push_data;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg)
            begin
                out_next       = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                // Receiver stalled: park the transaction in the skid stage
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_reg.read_data;
    assign rsp.handled   = out_reg.handled;

endmodule
`default_nettype wire

// ===== rtl/game_port_joystick_emulator_core.sv =====
// Game port joystick emulator.
// req carries one bus event per transaction: a port read, a port write, a
// counter tick or a microsecond tick. Only a read yields a transaction on rsp
// (read_data and handled); the others update internal state and yield nothing.
// cfg writes register 0 (serial pad mode) and register 1 (players present);
// it is always ready and should only be written while the block is idle.
// Throughput: one req transaction per clock while req.ready is high. A read's
// response is registered before it is valid on rsp. Every event acts on the
// state at its accepting edge, so a read sees all earlier writes and ticks.
// Stalls: an output register plus one skid entry hold responses; req.ready
// drops only when both are full and recovers as soon as rsp takes one.
// Reset clears the four axis counters (idle), the serial frame phase, both
// configuration registers and the response buffer; hold req.valid and
// cfg.valid low while rst_n is low.
`default_nettype none
module game_port_joystick_emulator_core #(
    parameter int HALF_BIT_US = gpje_pkg::HALF_BIT_US
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    gpje_req_if.sink    req,
    gpje_rsp_if.source  rsp,
    gpje_cfg_if.sink    cfg
);

    logic                                   serial_pad_mode_reg;
    logic                                   players_present_reg;
    logic                                   req_fire;
    logic                                   space;
    logic                                   port_hit;
    gpje_pkg::timer_ctl_t                   ctl;
    gpje_pkg::rsp_t                         rd_rsp;
    logic [gpje_pkg::NUM_AXES-1:0]          running;
    logic [gpje_pkg::STEP_W-1:0]            step;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            serial_pad_mode_reg <= 1'b0;
            players_present_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (gpje_pkg::cfg_idx_t'(cfg.index))
                gpje_pkg::CFG_SERIAL_MODE: serial_pad_mode_reg <= cfg.data;
                gpje_pkg::CFG_PLAYERS:     players_present_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    assign req.ready = space;
    assign req_fire  = req.valid && space;
    assign port_hit  = (req.port_low == gpje_pkg::JOY_PORT);

    assign ctl.load       = req_fire && (req.opcode == gpje_pkg::OP_WRITE) && port_hit;
    assign ctl.count_tick = req_fire && (req.opcode == gpje_pkg::OP_CNT_TICK);
    assign ctl.us_tick    = req_fire && (req.opcode == gpje_pkg::OP_US_TICK);

    gpje_timers #(
        .HALF_BIT_US (HALF_BIT_US)
    ) u_timers (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .axis_a_x (req.axis_a_x),
        .axis_a_y (req.axis_a_y),
        .axis_b_x (req.axis_b_x),
        .axis_b_y (req.axis_b_y),
        .running  (running),
        .step     (step)
    );

    gpje_read_mux u_read_mux (
        .serial_pad_mode (serial_pad_mode_reg),
        .players_present (players_present_reg),
        .port_low        (req.port_low),
        .button_bits     (req.button_bits),
        .pad_frame       (req.pad_frame),
        .running         (running),
        .step            (step),
        .rsp             (rd_rsp)
    );

    gpje_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (req_fire && (req.opcode == gpje_pkg::OP_READ)),
        .push_data (rd_rsp),
        .space     (space),
        .rsp       (rsp)
    );

endmodule
`default_nettype wire
